>>> src/pidtf_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Shared types and constants for the two-form PID controller.
// ----------------------------------------------------------------------------
package pidtf_pkg;

  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FORM_SELECT = 3'd7;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_WB_P,
    ST_MUL_I,
    ST_WB_I,
    ST_MUL_D,
    ST_WB_D,
    ST_ACC,
    ST_SUM,
    ST_CLEAR,
    ST_LOAD
  } state_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    MSEL_P,
    MSEL_I,
    MSEL_D
  } mul_sel_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     diff_en;
    logic     load_p;
    logic     load_g;
    logic     load_d;
    logic     acc_en;
    logic     sum_en;
    logic     clear_en;
    logic     load_out;
  } dp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic serial;
  } dp_status_t;

endpackage

>>> src/pidtf_if.sv
// ----------------------------------------------------------------------------
// PID controller channel interfaces
// Valid/ready channels for the step items and the result items.
// ----------------------------------------------------------------------------
interface pidtf_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;

  modport source (output valid, mode, setpoint, measured, input ready);
  modport sink   (input valid, mode, setpoint, measured, output ready);
endinterface

interface pidtf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               integ_clamped;
  logic               drive_clamped;

  modport source (output valid, drive, integ_clamped, drive_clamped, input ready);
  modport sink   (input valid, drive, integ_clamped, drive_clamped, output ready);
endinterface

>>> src/pidtf_datapath.sv
// ----------------------------------------------------------------------------
// PID controller datapath
// Configuration registers, shared multiplier, terms, history and result.
// ----------------------------------------------------------------------------
module pidtf_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_wdata,
  input  pidtf_pkg::dp_cmd_t     cmd,
  output pidtf_pkg::dp_status_t  status,
  input  logic signed [31:0]     setpoint,
  input  logic signed [31:0]     measured,
  output logic signed [31:0]     drive,
  output logic                   integ_clamped,
  output logic                   drive_clamped
);
  import pidtf_pkg::*;

  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  logic signed [31:0] prop_gain, integ_gain, deriv_gain;
  logic signed [31:0] integ_upper, integ_lower, drive_upper, drive_lower;
  logic               form_select;

  logic signed [31:0] err, diff, last_error, integral_acc;
  logic signed [31:0] p_term, g_term, d_term;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] res_drive;
  logic               res_ihit, res_dhit;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Arithmetic right shift floors; then saturate the 64-bit value to 32 bits.
  function automatic logic signed [31:0] qsat(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v >>> FRAC_BITS;
    if ((&s[63:31]) || !(|s[63:31])) begin
      return s[31:0];
    end
    return s[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  // Upper test first: with crossed limits a value above the upper limit takes it and any other takes the lower.
  function automatic logic [32:0] clamp(input logic signed [31:0] v,
                                        input logic signed [31:0] hi,
                                        input logic signed [31:0] lo);
    if (v > hi) begin
      return {1'b1, hi};
    end else if (v < lo) begin
      return {1'b1, lo};
    end
    return {1'b0, v};
  endfunction

  logic signed [31:0] acc_sum;
  logic [32:0]        acc_clamped;
  logic signed [31:0] d_eff;
  logic signed [31:0] out_sum;
  logic [32:0]        out_clamped;

  assign status.serial = form_select;

  always_comb begin
    case (cmd.mul_sel)
      MSEL_P: begin
        mul_a = prop_gain;
        mul_b = err;
      end
      MSEL_I: begin
        mul_a = integ_gain;
        mul_b = form_select ? p_term : err;
      end
      MSEL_D: begin
        mul_a = deriv_gain;
        mul_b = diff;
      end
      default: begin
        mul_a = prop_gain;
        mul_b = err;
      end
    endcase
  end

  assign acc_sum     = sat34({{2{integral_acc[31]}}, integral_acc} +
                             {{2{g_term[31]}}, g_term});
  assign acc_clamped = clamp(acc_sum, integ_upper, integ_lower);
  assign d_eff       = form_select ? 32'sd0 : d_term;
  assign out_sum     = sat34({{2{p_term[31]}}, p_term} +
                             {{2{integral_acc[31]}}, integral_acc} +
                             {{2{d_eff[31]}}, d_eff});
  assign out_clamped = clamp(out_sum, drive_upper, drive_lower);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_upper <= 32'sh7FFFFFFF;
      integ_lower <= 32'sh80000000;
      drive_upper <= 32'sh7FFFFFFF;
      drive_lower <= 32'sh80000000;
      form_select <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:   prop_gain   <= cfg_wdata;
        REG_INTEG_GAIN:  integ_gain  <= cfg_wdata;
        REG_DERIV_GAIN:  deriv_gain  <= cfg_wdata;
        REG_INTEG_UPPER: integ_upper <= cfg_wdata;
        REG_INTEG_LOWER: integ_lower <= cfg_wdata;
        REG_DRIVE_UPPER: drive_upper <= cfg_wdata;
        REG_DRIVE_LOWER: drive_lower <= cfg_wdata;
        REG_FORM_SELECT: form_select <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Controller history.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      last_error   <= '0;
    end else if (cmd.clear_en) begin
      integral_acc <= '0;
      last_error   <= '0;
    end else begin
      if (cmd.acc_en) begin
        integral_acc <= acc_clamped[31:0];
      end
      if (cmd.load_d) begin
        last_error <= err;
      end
    end
  end

  // Working registers and result staging.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err <= sat34({{2{setpoint[31]}}, setpoint} - {{2{measured[31]}}, measured});
    end
    if (cmd.diff_en) begin
      diff <= sat34({{2{err[31]}}, err} - {{2{last_error[31]}}, last_error});
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.load_p) begin
      p_term <= qsat(prod);
    end
    if (cmd.load_g) begin
      g_term <= qsat(prod);
    end
    if (cmd.load_d) begin
      d_term <= qsat(prod);
    end
    if (cmd.acc_en) begin
      res_ihit <= acc_clamped[32];
    end
    if (cmd.sum_en) begin
      res_drive <= out_clamped[31:0];
      res_dhit  <= out_clamped[32];
    end
    if (cmd.clear_en) begin
      res_drive <= '0;
      res_ihit  <= 1'b0;
      res_dhit  <= 1'b0;
    end
    if (cmd.load_out) begin
      drive         <= res_drive;
      integ_clamped <= res_ihit;
      drive_clamped <= res_dhit;
    end
  end

endmodule

>>> src/pidtf_ctrl.sv
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps the datapath through one control step and owns the handshakes.
// ----------------------------------------------------------------------------
module pidtf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pidtf_pkg::dp_cmd_t    cmd,
  input  pidtf_pkg::dp_status_t status
);
  import pidtf_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) begin
                  state_next = in_mode ? ST_CLEAR : ST_MUL_P;
                end
      ST_MUL_P: state_next = ST_WB_P;
      ST_WB_P:  state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_WB_I;
      ST_WB_I:  state_next = status.serial ? ST_ACC : ST_MUL_D;
      ST_MUL_D: state_next = ST_WB_D;
      ST_WB_D:  state_next = ST_ACC;
      ST_ACC:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_LOAD;
      ST_CLEAR: state_next = ST_LOAD;
      ST_LOAD:  if (out_free) begin
                  state_next = ST_IDLE;
                end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_sel = MSEL_P;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P;
        cmd.diff_en = 1'b1;
      end
      ST_WB_P:  cmd.load_p = 1'b1;
      ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_I;
      end
      ST_WB_I:  cmd.load_g = 1'b1;
      ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_D;
      end
      ST_WB_D:  cmd.load_d = 1'b1;
      ST_ACC:   cmd.acc_en = 1'b1;
      ST_SUM:   cmd.sum_en = 1'b1;
      ST_CLEAR: cmd.clear_en = 1'b1;
      ST_LOAD:  cmd.load_out = out_free;
      default:  ;
    endcase
  end

endmodule

>>> src/pid_controller_two_forms_top.sv
// ----------------------------------------------------------------------------
// Two-form PID controller, top level
// Positional PID regulator in signed Q16.16 with integral and output clamps.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake         Beat contents
//   in_ch     in   valid / ready     mode, setpoint, measured
//   out_ch    out  valid / ready     drive, integ_clamped, drive_clamped
//   cfg       in   cfg_we            cfg_index, cfg_wdata (no read-back)
//
// A run beat steps through multiply and write-back states for each product
// (the derivative pair in parallel form only), accumulation and the sum to
// the output register; a clear beat passes through the clear state. No new
// beat is taken until the last is through. The single shared 32x32 multiplier
// serves up to three products in turn, with a register after each.
// Reset is synchronous and active high; it restores the register defaults
// and zeroes the integral and the previous error.
// The next input beat is accepted once the result has moved into the output
// register, even while that result still waits on a stalled output.
module pid_controller_two_forms_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  pidtf_in_if.sink    in_ch,
  pidtf_out_if.source out_ch
);
  import pidtf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The sequencer walks error capture, the multiplies, accumulation and the
  // output sum; it also holds the result valid flag.
  pidtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath keeps the configuration, the history and the result
  // register that drives the output channel directly.
  pidtf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .status        (status),
    .setpoint      (in_ch.setpoint),
    .measured      (in_ch.measured),
    .drive         (out_ch.drive),
    .integ_clamped (out_ch.integ_clamped),
    .drive_clamped (out_ch.drive_clamped)
  );

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Two-form PID controller testbench
// Drives step and clear beats into the controller through randomly paced
// valid/ready channels, rewrites the gains, limits and form between phases,
// and checks every result beat against a fixed-point predictor kept in step
// with the accepted input beats.
// ----------------------------------------------------------------------------
module testbench;
  import pidtf_pkg::*;

  localparam int FRAC = 16;
  localparam int Q_ONE = 65536;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // Item and form codes.
  localparam logic STEP_RUN = 1'b0;
  localparam logic STEP_CLEAR = 1'b1;
  localparam logic FORM_PARALLEL = 1'b0;
  localparam logic FORM_SERIAL = 1'b1;

  // The tail wait after the last result and the overall cycle budget are
  // sized from the time that a run beat needs inside the block.
  localparam int TAIL_CYCLES = 24;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int MAX_REPORTS = 20;

  typedef struct {
    logic signed [31:0] drive;
    logic               integ_clamped;
    logic               drive_clamped;
  } pid_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  pidtf_in_if  in_ch ();
  pidtf_out_if out_ch ();

  pid_controller_two_forms_top #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow of the configuration registers, at their reset values.
  longint prop_gain_r = 0;
  longint integ_gain_r = 0;
  longint deriv_gain_r = 0;
  longint integ_upper_r = 64'sd2147483647;
  longint integ_lower_r = -64'sd2147483648;
  longint drive_upper_r = 64'sd2147483647;
  longint drive_lower_r = -64'sd2147483648;
  logic   form_r = FORM_PARALLEL;

  // Shadow of the controller history.
  longint integral_q = 0;
  longint prev_error_q = 0;

  // Results predicted for accepted beats, oldest first.
  pid_result_t drive_expect_q[$];

  // Pacing controls shared by the stimulus and the output-ready process.
  bit src_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;
  int hold_off_len = 0;

  int unsigned cycle_count = 0;
  int errors = 0;
  int items_sent = 0;
  int clears_sent = 0;
  int results_seen = 0;
  int integ_hits = 0;
  int drive_hits = 0;
  int reg_writes = 0;

  // Clock: 20 time units per period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results still pending", $time,
               CYCLE_LIMIT, drive_expect_q.size());
      $display("pid_controller_two_forms_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the controller.
  // ---------------------------------------------------------------------------

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Full product, arithmetic shift (floor), then saturation to 32 bits.
  function automatic longint qmul(input longint a, input longint b);
    return sat32((a * b) >>> FRAC);
  endfunction

  // The upper test wins when the limits are crossed.
  function automatic longint clamp_to(input longint v, input longint hi, input longint lo,
                                      output bit hit);
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Advances the controller shadow by one accepted beat and queues the
  // result that the block must produce for it.
  task automatic predict_drive(input logic mode, input logic [31:0] sp, input logic [31:0] ms);
    pid_result_t res;
    longint err;
    longint p;
    longint d;
    longint gain;
    longint acc;
    longint total;
    bit ihit;
    bit dhit;
    d = 0;
    if (mode == STEP_CLEAR) begin
      integral_q = 0;
      prev_error_q = 0;
      res.drive = '0;
      res.integ_clamped = 1'b0;
      res.drive_clamped = 1'b0;
    end else begin
      err = sat32(longint'(signed'(sp)) - longint'(signed'(ms)));
      p = qmul(prop_gain_r, err);
      if (form_r == FORM_SERIAL) begin
        // Serial form: the integral sees the proportional term and the
        // stored error is left alone.
        gain = qmul(integ_gain_r, p);
      end else begin
        gain = qmul(integ_gain_r, err);
        d = qmul(deriv_gain_r, sat32(err - prev_error_q));
        prev_error_q = err;
      end
      acc = clamp_to(sat32(integral_q + gain), integ_upper_r, integ_lower_r, ihit);
      integral_q = acc;
      total = clamp_to(sat32(p + acc + d), drive_upper_r, drive_lower_r, dhit);
      res.drive = total[31:0];
      res.integ_clamped = ihit;
      res.drive_clamped = dhit;
      integ_hits += int'(ihit);
      drive_hits += int'(dhit);
    end
    drive_expect_q.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers.
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // A Q16.16 value: mostly within +-span, sometimes any 32 bits or an extreme.
  function automatic logic [31:0] pick_value(input int unsigned span);
    case ($urandom_range(0, 9))
      0: return S32_MAX;
      1: return S32_MIN;
      2, 3: return $urandom();
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel and register drivers.
  // ---------------------------------------------------------------------------

  // One register write; the following idle cycle keeps each write enable
  // pulse separate.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROP_GAIN:   prop_gain_r = longint'(signed'(value));
      REG_INTEG_GAIN:  integ_gain_r = longint'(signed'(value));
      REG_DERIV_GAIN:  deriv_gain_r = longint'(signed'(value));
      REG_INTEG_UPPER: integ_upper_r = longint'(signed'(value));
      REG_INTEG_LOWER: integ_lower_r = longint'(signed'(value));
      REG_DRIVE_UPPER: drive_upper_r = longint'(signed'(value));
      REG_DRIVE_LOWER: drive_lower_r = longint'(signed'(value));
      REG_FORM_SELECT: form_r = value[0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic write_gains(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
  endtask

  task automatic write_limits(input logic [31:0] i_hi, input logic [31:0] i_lo,
                              input logic [31:0] d_hi, input logic [31:0] d_lo);
    write_reg(REG_INTEG_UPPER, i_hi);
    write_reg(REG_INTEG_LOWER, i_lo);
    write_reg(REG_DRIVE_UPPER, d_hi);
    write_reg(REG_DRIVE_LOWER, d_lo);
  endtask

  // Offers one beat and returns at the edge that accepts it. Valid stays high
  // on return so that the next beat can follow without a bubble; a gap, when
  // one is drawn, lowers it first.
  task automatic send_step(input logic mode, input logic [31:0] sp, input logic [31:0] ms);
    int gap;
    gap = src_idle_on ? idle_length() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.setpoint <= sp;
    in_ch.measured <= ms;
    do @(posedge clk); while (!in_ch.ready);
    predict_drive(mode, sp, ms);
    items_sent++;
    if (mode == STEP_CLEAR) clears_sent++;
  endtask

  // Stops offering beats and waits until every predicted result is back, so
  // the block is idle and may be reconfigured.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (drive_expect_q.size() != 0);
  endtask

  // Output side: random stalls when enabled, and a long counted hold-off
  // whenever a test asks for one.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        out_ch.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        stall = idle_length() + 1;
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  // Every accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    pid_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (drive_expect_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, drive %0d", $time,
                   out_ch.drive);
      end else begin
        want = drive_expect_q.pop_front();
        if (out_ch.drive !== want.drive)
          report_mismatch("drive", longint'(want.drive), longint'(out_ch.drive));
        if (out_ch.integ_clamped !== want.integ_clamped)
          report_mismatch("integ_clamped", longint'(want.integ_clamped),
                          longint'(out_ch.integ_clamped));
        if (out_ch.drive_clamped !== want.drive_clamped)
          report_mismatch("drive_clamped", longint'(want.drive_clamped),
                          longint'(out_ch.drive_clamped));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // With the reset gains of zero every step must give a zero drive, even for
  // the widest error; a clear beat is also zero.
  task automatic test_reset_defaults();
    send_step(STEP_RUN, S32_MAX, S32_MIN);
    send_step(STEP_RUN, S32_MIN, S32_MAX);
    send_step(STEP_CLEAR, S32_MAX, S32_MAX);
    drain_results();
  endtask

  // Extreme gains drive the products and sums into saturation, including the
  // saturated error and error difference. Then small gains with errors of one
  // and three LSBs show that negative products round toward minus infinity.
  task automatic test_parallel_products();
    write_reg(REG_FORM_SELECT, 32'(FORM_PARALLEL));
    write_gains(S32_MAX, S32_MAX, S32_MIN);
    send_step(STEP_RUN, S32_MAX, S32_MIN);
    send_step(STEP_RUN, S32_MIN, S32_MAX);
    send_step(STEP_RUN, 32'd0, 32'd0);
    send_step(STEP_CLEAR, 32'd0, 32'd0);
    send_step(STEP_RUN, 32'd1, 32'd0);
    drain_results();
    write_gains(Q_ONE / 2, -(Q_ONE / 2), 3 * Q_ONE / 2);
    send_step(STEP_RUN, 32'd1, 32'd0);
    send_step(STEP_RUN, 32'd0, 32'd1);
    send_step(STEP_RUN, 32'd3, 32'd0);
    send_step(STEP_RUN, -3, 32'd0);
    drain_results();
  endtask

  // Serial form feeds the proportional term to the integral and must keep
  // the stored error; the first parallel step afterwards shows which error
  // the derivative differences against.
  task automatic test_serial_form();
    write_gains(2 * Q_ONE, Q_ONE / 4, Q_ONE);
    send_step(STEP_RUN, 4 * Q_ONE, Q_ONE);
    drain_results();
    write_reg(REG_FORM_SELECT, 32'(FORM_SERIAL));
    send_step(STEP_RUN, 10 * Q_ONE, 4 * Q_ONE);
    send_step(STEP_RUN, -3 * Q_ONE, 2 * Q_ONE);
    drain_results();
    write_reg(REG_FORM_SELECT, 32'(FORM_PARALLEL));
    send_step(STEP_RUN, 7 * Q_ONE, 0);
    drain_results();
  endtask

  // The integral and the output saturate against narrow limits, then against
  // crossed limits where the upper test must take precedence.
  task automatic test_limits();
    write_gains(Q_ONE, Q_ONE, 0);
    write_limits(5 * Q_ONE, -5 * Q_ONE, 8 * Q_ONE, -8 * Q_ONE);
    send_step(STEP_CLEAR, 0, 0);
    send_step(STEP_RUN, 3 * Q_ONE, 0);
    send_step(STEP_RUN, 3 * Q_ONE, 0);
    send_step(STEP_RUN, -20 * Q_ONE, 0);
    drain_results();
    write_limits(-Q_ONE, Q_ONE, 32'd0, S32_MAX);
    send_step(STEP_RUN, 0, 0);
    send_step(STEP_RUN, -4 * Q_ONE, 0);
    drain_results();
  endtask

  // The output side holds off for a long, counted stretch while the input
  // side keeps offering beats back to back, so the block fills and stalls
  // its input. The sender then waits until every result has come back.
  task automatic test_output_hold_off();
    int k;
    write_gains(Q_ONE, Q_ONE / 8, Q_ONE / 2);
    write_limits(S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_off_len = 300;
    for (k = 0; k < 24; k++)
      send_step(STEP_RUN, pick_value(1 << 20), pick_value(1 << 20));
    drain_results();
  endtask

  // Limits drawn as full range, ordered, crossed or equal.
  task automatic write_random_limits(input logic [2:0] hi_idx, input logic [2:0] lo_idx);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] t;
    hi = pick_value(1 << 22);
    lo = pick_value(1 << 22);
    case ($urandom_range(0, 4))
      0: begin
        hi = S32_MAX;
        lo = S32_MIN;
      end
      1, 2: if (signed'(hi) < signed'(lo)) begin
        t = hi;
        hi = lo;
        lo = t;
      end
      3: if (signed'(hi) > signed'(lo)) begin
        t = hi;
        hi = lo;
        lo = t;
      end
      default: lo = hi;
    endcase
    write_reg(hi_idx, hi);
    write_reg(lo_idx, lo);
  endtask

  // Phases of random beats, each under its own settings. The first phases
  // use extreme gains and limits; pacing varies from phase to phase, the
  // first running with no idling on either side.
  task automatic test_random_phases();
    int ph;
    int k;
    logic mode;
    logic [31:0] sp;
    logic [31:0] ms;
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph < 2) begin
        write_gains(ph == 0 ? S32_MAX : S32_MIN, ph == 0 ? S32_MIN : S32_MAX,
                    ph == 0 ? S32_MAX : S32_MIN);
        if (ph == 0) write_limits(S32_MIN, S32_MAX, S32_MAX, S32_MIN);
        else write_limits(S32_MAX, S32_MIN, S32_MIN, S32_MAX);
      end else begin
        write_gains(pick_value(1 << 17), pick_value(1 << 15), pick_value(1 << 16));
        write_random_limits(REG_INTEG_UPPER, REG_INTEG_LOWER);
        write_random_limits(REG_DRIVE_UPPER, REG_DRIVE_LOWER);
      end
      write_reg(REG_FORM_SELECT,
                32'($urandom_range(0, 1) ? FORM_SERIAL : FORM_PARALLEL));
      src_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      sink_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        mode = ($urandom_range(0, 99) < 6) ? STEP_CLEAR : STEP_RUN;
        sp = pick_value(1 << 21);
        // Measurements mostly track the setpoint closely, as in a loop that
        // has settled; the rest are unrelated.
        if ($urandom_range(0, 2) == 0) ms = pick_value(1 << 21);
        else ms = sp + $urandom_range(0, 1 << 19) - (1 << 18);
        send_step(mode, sp, ms);
      end
    end
    drain_results();
  endtask

  // Main sequence: reset once, then the tests in turn, then the verdict.
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_PROP_GAIN;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= STEP_RUN;
    in_ch.setpoint <= '0;
    in_ch.measured <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_parallel_products();
    test_serial_form();
    test_limits();
    test_output_hold_off();
    test_random_phases();

    // Let any stray result beat surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (drive_expect_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, drive_expect_q.size());
    end

    $display("Sent %0d beats (%0d clears) across %0d register writes; %0d results checked.",
             items_sent, clears_sent, reg_writes, results_seen);
    $display("Integral limit hit %0d times, output limit hit %0d times; %0d errors.",
             integ_hits, drive_hits, errors);
    if (errors == 0) begin
      $display("pid_controller_two_forms_top: match");
    end else begin
      $display("pid_controller_two_forms_top: mismatch");
    end
    $finish;
  end

endmodule
